>>> hw/rtl/psdw_pkg.sv
package psdw_pkg;

	// Image dimension limits and register widths.
	localparam int MAX_DIMENSION = 4096;
	localparam int DIM_W = 13;
	localparam int CNT_W = 12;

	// Register indexes on the configuration port.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Queue between the front and back parts.
	localparam int QUEUE_AW = 1;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	// Byte index within one emission phase.
	localparam int IDX_W = 6;
	localparam logic [IDX_W-1:0] FILE_LAST_IDX = 6'd42;
	localparam logic [IDX_W-1:0] ROW_LAST_IDX  = 6'd5;
	localparam logic [IDX_W-1:0] PIX_LAST_IDX  = 6'd3;
	localparam logic [IDX_W-1:0] TRL_LAST_IDX  = 6'd19;

	// Emission phases of the back part.
	typedef enum logic [1:0] {
		PH_FILE,
		PH_ROW,
		PH_PIX,
		PH_TRL
	} psdw_phase_t;

	// One classified pixel, as handed from the front to the back.
	typedef struct packed {
		logic [31:0] pixel;
		logic        file_start;
		logic        row_start;
		logic        row_last;
		logic        trailer;
		logic        trailer_only;
	} psdw_entry_t;

	// A zero dimension is used as one, an oversized one as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIMENSION)) begin
			return DIM_W'(MAX_DIMENSION);
		end else begin
			return v;
		end
	endfunction

endpackage

>>> hw/rtl/psdw_front.sv
module psdw_front
	import psdw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,
	input  logic [DIM_W-1:0]  width_cl,
	input  logic [DIM_W-1:0]  height_cl,
	input  logic              queue_full,
	output logic              push,
	output psdw_entry_t       push_entry
);

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic             pending_q;
	logic             col_end;
	logic             row_end;
	logic             first_px;

	assign s_tready = !queue_full;
	assign push     = s_tvalid && s_tready;

	// Classify the pixel from the position counters.
	assign first_px = (col_q == '0) && (row_q == '0);
	assign col_end  = ({1'b0, col_q} + DIM_W'(1)) >= width_cl;
	assign row_end  = ({1'b0, row_q} + DIM_W'(1)) >= height_cl;

	always_comb begin
		push_entry.pixel        = s_tdata;
		push_entry.trailer_only = pending_q;
		push_entry.file_start   = !pending_q && first_px;
		push_entry.row_start    = !pending_q && (col_q == '0);
		push_entry.row_last     = row_end;
		// A one-pixel image defers its trailer to the next word.
		push_entry.trailer      = !pending_q && col_end && row_end && !first_px;
	end

	// Position counters and the deferred trailer flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			pending_q <= 1'b0;
		end else if (push) begin
			if (pending_q) begin
				pending_q <= 1'b0;
			end else if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q     <= '0;
					pending_q <= first_px;
				end else begin
					row_q <= row_q + CNT_W'(1);
				end
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/psdw_fifo.sv
module psdw_fifo
	import psdw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  psdw_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output psdw_entry_t head
);

	psdw_entry_t         entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");

endmodule

>>> hw/rtl/psdw_back.sv
module psdw_back
	import psdw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] width_cl,
	input  logic [DIM_W-1:0] height_cl,
	input  logic             queue_empty,
	input  psdw_entry_t      head,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	output logic             m_tuser
);

	localparam logic [16:0] ADLER_MOD = 17'd65521;

	psdw_phase_t      phase_q;
	logic [IDX_W-1:0] idx_q;
	logic             active_q;
	logic [31:0]      crc_q;
	logic [15:0]      adler_lo_q;
	logic [15:0]      adler_hi_q;
	logic [27:0]      idat_len_q;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic             m_tlast_q;
	logic             m_tuser_q;

	psdw_phase_t      cur_phase;
	psdw_phase_t      next_phase;
	logic [IDX_W-1:0] cur_idx;
	logic [IDX_W-1:0] last_idx;
	logic             fire;
	logic             phase_end;
	logic             entry_end;
	logic             file_done;
	logic [7:0]       byte_out;
	logic             use_crc;
	logic             crc_clear;
	logic             use_adler;
	logic [31:0]      crc_base;
	logic [31:0]      crc_next;
	logic [31:0]      crc_out;
	logic [31:0]      w32;
	logic [31:0]      h32;
	logic [31:0]      len32;
	logic [31:0]      adler32;
	logic [15:0]      row_len;
	logic [16:0]      lo_sum;
	logic [15:0]      lo_next;
	logic [16:0]      hi_sum;
	logic [15:0]      hi_next;
	logic [14:0]      row_span;

	// Reflected CRC-32 over one byte, one bit per step.
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		end
		return c;
	endfunction

	// Byte k of a word, most significant first.
	function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0:    r = v[31:24];
			2'd1:    r = v[23:16];
			2'd2:    r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

	// IDAT length: 6 + height * (6 + 4 * width), registered off the multiplier.
	assign row_span = {width_cl, 2'b00} + 15'd6;
	always_ff @(posedge clk) begin
		idat_len_q <= 28'(row_span) * 28'(height_cl) + 28'd6;
	end

	assign w32      = {19'h0, width_cl};
	assign h32      = {19'h0, height_cl};
	assign len32    = {4'h0, idat_len_q};
	assign adler32  = {adler_hi_q, adler_lo_q};
	assign row_len  = {1'b0, width_cl, 2'b00} + 16'd1;
	assign crc_out  = ~crc_q;

	// Current phase: a fresh head word starts from its own first phase.
	always_comb begin
		if (active_q) begin
			cur_phase = phase_q;
			cur_idx   = idx_q;
		end else begin
			cur_idx = '0;
			if (head.trailer_only) begin
				cur_phase = PH_TRL;
			end else if (head.file_start) begin
				cur_phase = PH_FILE;
			end else if (head.row_start) begin
				cur_phase = PH_ROW;
			end else begin
				cur_phase = PH_PIX;
			end
		end
	end

	// Byte selection, checksum enables and phase sequencing.
	always_comb begin
		byte_out   = 8'h00;
		use_crc    = 1'b0;
		crc_clear  = 1'b0;
		use_adler  = 1'b0;
		last_idx   = PIX_LAST_IDX;
		next_phase = PH_PIX;
		case (cur_phase)
			PH_FILE: begin
				last_idx   = FILE_LAST_IDX;
				next_phase = PH_ROW;
				use_crc    = cur_idx inside {[6'd12:6'd28], [6'd37:6'd42]};
				crc_clear  = (cur_idx == 6'd12) || (cur_idx == 6'd37);
				case (cur_idx)
					6'd0:  byte_out = 8'h89;
					6'd1:  byte_out = 8'h50;
					6'd2:  byte_out = 8'h4E;
					6'd3:  byte_out = 8'h47;
					6'd4:  byte_out = 8'h0D;
					6'd5:  byte_out = 8'h0A;
					6'd6:  byte_out = 8'h1A;
					6'd7:  byte_out = 8'h0A;
					6'd11: byte_out = 8'h0D;
					6'd12: byte_out = 8'h49;
					6'd13: byte_out = 8'h48;
					6'd14: byte_out = 8'h44;
					6'd15: byte_out = 8'h52;
					6'd16, 6'd17, 6'd18, 6'd19: byte_out = be_byte(w32, cur_idx[1:0]);
					6'd20, 6'd21, 6'd22, 6'd23: byte_out = be_byte(h32, cur_idx[1:0]);
					6'd24: byte_out = 8'h08;
					6'd25: byte_out = 8'h06;
					6'd29, 6'd30, 6'd31, 6'd32: byte_out = be_byte(crc_out, 2'(cur_idx - 6'd29));
					6'd33, 6'd34, 6'd35, 6'd36: byte_out = be_byte(len32, 2'(cur_idx - 6'd33));
					6'd37: byte_out = 8'h49;
					6'd38: byte_out = 8'h44;
					6'd39: byte_out = 8'h41;
					6'd40: byte_out = 8'h54;
					6'd41: byte_out = 8'h78;
					6'd42: byte_out = 8'h01;
					default: byte_out = 8'h00;
				endcase
			end
			PH_ROW: begin
				last_idx   = ROW_LAST_IDX;
				next_phase = PH_PIX;
				use_crc    = 1'b1;
				use_adler  = cur_idx == ROW_LAST_IDX;
				case (cur_idx)
					6'd0:    byte_out = {7'h0, head.row_last};
					6'd1:    byte_out = row_len[7:0];
					6'd2:    byte_out = row_len[15:8];
					6'd3:    byte_out = ~row_len[7:0];
					6'd4:    byte_out = ~row_len[15:8];
					default: byte_out = 8'h00;
				endcase
			end
			PH_PIX: begin
				last_idx   = PIX_LAST_IDX;
				next_phase = PH_TRL;
				use_crc    = 1'b1;
				use_adler  = 1'b1;
				case (cur_idx[1:0])
					2'd0:    byte_out = head.pixel[7:0];
					2'd1:    byte_out = head.pixel[15:8];
					2'd2:    byte_out = head.pixel[23:16];
					default: byte_out = head.pixel[31:24];
				endcase
			end
			PH_TRL: begin
				last_idx   = TRL_LAST_IDX;
				next_phase = PH_TRL;
				use_crc    = cur_idx inside {[6'd0:6'd3], [6'd12:6'd15]};
				crc_clear  = cur_idx == 6'd12;
				case (cur_idx)
					6'd0, 6'd1, 6'd2, 6'd3:     byte_out = be_byte(adler32, cur_idx[1:0]);
					6'd4, 6'd5, 6'd6, 6'd7:     byte_out = be_byte(crc_out, cur_idx[1:0]);
					6'd12: byte_out = 8'h49;
					6'd13: byte_out = 8'h45;
					6'd14: byte_out = 8'h4E;
					6'd15: byte_out = 8'h44;
					6'd16, 6'd17, 6'd18, 6'd19: byte_out = be_byte(crc_out, cur_idx[1:0]);
					default: byte_out = 8'h00;
				endcase
			end
			default: begin
				byte_out = 8'h00;
			end
		endcase
	end

	assign phase_end = cur_idx == last_idx;
	assign entry_end = phase_end &&
		((cur_phase == PH_TRL) || ((cur_phase == PH_PIX) && !head.trailer));
	assign file_done = (cur_phase == PH_TRL) && phase_end;
	assign fire      = !queue_empty && (!m_tvalid_q || m_tready);
	assign pop       = fire && entry_end;

	// Checksum updates for the byte going out.
	assign crc_base = crc_clear ? 32'hFFFFFFFF : crc_q;
	assign crc_next = crc_byte(crc_base, byte_out);
	assign lo_sum   = {1'b0, adler_lo_q} + {9'h0, byte_out};
	assign lo_next  = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
	assign hi_sum   = {1'b0, adler_hi_q} + {1'b0, lo_next};
	assign hi_next  = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

	// Phase state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PIX;
			idx_q    <= '0;
			active_q <= 1'b0;
		end else if (fire) begin
			if (entry_end) begin
				active_q <= 1'b0;
				idx_q    <= '0;
			end else if (phase_end) begin
				active_q <= 1'b1;
				phase_q  <= next_phase;
				idx_q    <= '0;
			end else begin
				active_q <= 1'b1;
				phase_q  <= cur_phase;
				idx_q    <= cur_idx + IDX_W'(1);
			end
		end
	end

	// Running CRC and Adler sums; a new file restarts the Adler sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= 32'hFFFFFFFF;
			adler_lo_q <= 16'd1;
			adler_hi_q <= 16'd0;
		end else if (fire) begin
			if (use_crc) begin
				crc_q <= crc_next;
			end
			if ((cur_phase == PH_FILE) && (cur_idx == '0)) begin
				adler_lo_q <= 16'd1;
				adler_hi_q <= 16'd0;
			end else if (use_adler) begin
				adler_lo_q <= lo_next;
				adler_hi_q <= hi_next;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= byte_out;
			m_tlast_q <= entry_end;
			m_tuser_q <= file_done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q |-> m_tlast_q)
		else $error("file end not on the last byte of a word");
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !queue_empty)
		else $error("word left the queue before its bytes were sent");

endmodule

>>> hw/rtl/png_stored_deflate_writer.sv
// PNG writer for 8-bit RGBA images, stored (uncompressed) deflate blocks.
// Pixels enter on the s_ channel in raster order as one word each; the
// PNG byte stream leaves on the m_ channel one byte per word. m_tlast
// marks the last byte caused by an input pixel, m_tuser the final byte of
// the file (last byte of the IEND CRC). Width and height are written on
// the cfg_ port between images; zero reads as one, values above 4096 as
// 4096. The first pixel of a file brings 53 bytes (signature, IHDR, IDAT
// header, zlib header, block header), the first pixel of any other row
// 10 bytes, other pixels 4 bytes; the last pixel adds 20 trailer bytes.
// A one-pixel image sends its trailer on the next accepted pixel, whose
// data is dropped. The back end sends one byte per cycle while a word is
// queued and the receiver is ready; pixels go through the queue, bytes
// through the output register. A two-word queue sits between pixel
// intake and the byte sequencer, so intake continues while the receiver
// stalls until the queue fills. Reset restores 64 x 64, begins a new file.
module png_stored_deflate_writer
	import psdw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // red, green, blue, alpha
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic             m_tlast,
	output logic             m_tuser,   // file_done
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] width_cl;
	logic [DIM_W-1:0] height_cl;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             queue_empty;
	psdw_entry_t      push_entry;
	psdw_entry_t      head;

	// Dimension registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(64);
			height_q <= DIM_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	assign width_cl  = clamp_dim(width_q);
	assign height_cl = clamp_dim(height_q);

	psdw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.width_cl   (width_cl),
		.height_cl  (height_cl),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	psdw_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.empty      (queue_empty),
		.head       (head)
	);

	psdw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.width_cl    (width_cl),
		.height_cl   (height_cl),
		.queue_empty (queue_empty),
		.head        (head),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

endmodule

>>> tb/png_stream_checker.sv
module png_stream_checker
	import psdw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [31:0]      s_tdata,   // red, green, blue, alpha
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [7:0]       m_tdata,   // out_byte
	input  logic             m_tlast,
	input  logic             m_tuser,   // file_done
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	output int               mismatch_count,
	output int               bytes_owed
);

	localparam logic [63:0] PNG_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;
	localparam logic [31:0] TAG_IHDR = "IHDR";
	localparam logic [31:0] TAG_IDAT = "IDAT";
	localparam logic [31:0] TAG_IEND = "IEND";
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam int unsigned ADLER_MOD = 65521;
	localparam int STEP_LIMIT = 53;
	localparam int TRAILER_LEN = 20;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       done;
	} png_byte_t;

	// Image state as the writer should hold it.
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [11:0]      col_cnt;
	logic [11:0]      row_cnt;
	logic [31:0]      crc_reg;
	int unsigned      adler_lo;
	int unsigned      adler_hi;
	bit               trailer_owed;

	// Bytes caused by the pixel being predicted, then the queue of all bytes still due.
	logic [7:0]       step_buf [0:79];
	int               step_len;
	int               done_idx;
	png_byte_t        expected_bytes [$];
	int               byte_no;

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTED) begin
			$display("mismatch at output byte %0d: %s", byte_no, what);
		end
		mismatch_count++;
	endtask

	// Zero is taken as one, anything above the maximum as the maximum.
	function automatic logic [31:0] dim_used(input logic [DIM_W-1:0] v);
		if (v == 0) begin
			return 32'd1;
		end else if (32'(v) > MAX_DIMENSION) begin
			return 32'(MAX_DIMENSION);
		end
		return 32'(v);
	endfunction

	// Appends one byte and folds it into the chunk CRC and the Adler sums as asked.
	task automatic put_byte(input logic [7:0] b, input bit to_crc, input bit to_adler);
		logic [31:0] c;
		int unsigned a;
		int i;
		if (to_crc) begin
			c = crc_reg ^ {24'd0, b};
			for (i = 0; i < 8; i++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
			crc_reg = c;
		end
		if (to_adler) begin
			a = adler_lo + b;
			if (a >= ADLER_MOD) a -= ADLER_MOD;
			adler_lo = a;
			a = adler_hi + adler_lo;
			if (a >= ADLER_MOD) a -= ADLER_MOD;
			adler_hi = a;
		end
		step_buf[step_len] = b;
		step_len++;
	endtask

	task automatic put_word(input logic [31:0] v, input bit to_crc);
		put_byte(v[31:24], to_crc, 1'b0);
		put_byte(v[23:16], to_crc, 1'b0);
		put_byte(v[15:8], to_crc, 1'b0);
		put_byte(v[7:0], to_crc, 1'b0);
	endtask

	// A chunk opens with its length, then the type, which starts a fresh CRC.
	task automatic open_chunk(input logic [31:0] len, input logic [31:0] tag);
		put_word(len, 1'b0);
		crc_reg = '1;
		put_word(tag, 1'b1);
	endtask

	task automatic close_chunk();
		put_word(~crc_reg, 1'b0);
	endtask

	// Adler word, IDAT CRC and the empty IEND chunk.
	task automatic put_trailer();
		put_word({adler_hi[15:0], adler_lo[15:0]}, 1'b1);
		close_chunk();
		open_chunk(32'd0, TAG_IEND);
		close_chunk();
		done_idx = step_len - 1;
	endtask

	// Works out every byte that one accepted pixel word brings.
	task automatic predict_pixel_bytes(input logic [31:0] px);
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] row_len;
		bit          image_end;
		png_byte_t   entry;
		int          i;
		step_len = 0;
		done_idx = -1;
		image_end = 1'b0;
		w = dim_used(width_reg);
		h = dim_used(height_reg);
		row_len = 32'd1 + 32'd4 * w;
		if (trailer_owed) begin
			// The pixel is dropped; only the trailer left over from a one-pixel image goes out.
			trailer_owed = 1'b0;
			put_trailer();
		end else begin
			if (col_cnt == 0 && row_cnt == 0) begin
				put_word(PNG_SIGNATURE[63:32], 1'b0);
				put_word(PNG_SIGNATURE[31:0], 1'b0);
				adler_lo = 1;
				adler_hi = 0;
				open_chunk(32'd13, TAG_IHDR);
				put_word(w, 1'b1);
				put_word(h, 1'b1);
				put_byte(8'd8, 1'b1, 1'b0);
				put_byte(8'd6, 1'b1, 1'b0);
				put_byte(8'd0, 1'b1, 1'b0);
				put_byte(8'd0, 1'b1, 1'b0);
				put_byte(8'd0, 1'b1, 1'b0);
				close_chunk();
				open_chunk(32'd2 + h * (32'd5 + row_len) + 32'd4, TAG_IDAT);
				put_byte(8'h78, 1'b1, 1'b0);
				put_byte(8'h01, 1'b1, 1'b0);
			end
			// Stored block header and filter byte at the start of each row.
			if (col_cnt == 0) begin
				put_byte((32'(row_cnt) + 32'd1 >= h) ? 8'd1 : 8'd0, 1'b1, 1'b0);
				put_byte(row_len[7:0], 1'b1, 1'b0);
				put_byte(row_len[15:8], 1'b1, 1'b0);
				put_byte(~row_len[7:0], 1'b1, 1'b0);
				put_byte(~row_len[15:8], 1'b1, 1'b0);
				put_byte(8'd0, 1'b1, 1'b1);
			end
			put_byte(px[7:0], 1'b1, 1'b1);
			put_byte(px[15:8], 1'b1, 1'b1);
			put_byte(px[23:16], 1'b1, 1'b1);
			put_byte(px[31:24], 1'b1, 1'b1);
			// Raster position, wrapping at the dimensions in force now.
			if (32'(col_cnt) + 32'd1 >= w) begin
				col_cnt = '0;
				if (32'(row_cnt) + 32'd1 >= h) begin
					row_cnt = '0;
					image_end = 1'b1;
				end else begin
					row_cnt = row_cnt + 12'd1;
				end
			end else begin
				col_cnt = col_cnt + 12'd1;
			end
			if (image_end) begin
				if (step_len + TRAILER_LEN > STEP_LIMIT) begin
					trailer_owed = 1'b1;
				end else begin
					put_trailer();
				end
			end
		end
		for (i = 0; i < step_len; i++) begin
			entry.value = step_buf[i];
			entry.last = (i == step_len - 1);
			entry.done = (i == done_idx);
			expected_bytes.push_back(entry);
		end
	endtask

	// Compares one output word with the oldest byte due.
	task automatic check_byte();
		png_byte_t want;
		if (expected_bytes.size() == 0) begin
			report_mismatch($sformatf("byte %02h arrived with none due", m_tdata));
		end else begin
			want = expected_bytes.pop_front();
			if (m_tdata !== want.value) begin
				report_mismatch($sformatf("data %02h, want %02h", m_tdata, want.value));
			end
			if (m_tlast !== want.last) begin
				report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
			end
			if (m_tuser !== want.done) begin
				report_mismatch($sformatf("tuser %b, want %b", m_tuser, want.done));
			end
		end
		byte_no++;
	endtask

	// Watch the register port and both streams at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = DIM_W'(64);
			height_reg = DIM_W'(64);
			col_cnt = '0;
			row_cnt = '0;
			crc_reg = '1;
			adler_lo = 1;
			adler_hi = 0;
			trailer_owed = 1'b0;
			expected_bytes.delete();
			byte_no = 0;
			mismatch_count = 0;
			bytes_owed = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) begin
					width_reg = cfg_data;
				end else begin
					height_reg = cfg_data;
				end
			end
			if (m_tvalid && m_tready) begin
				check_byte();
			end
			if (s_tvalid && s_tready) begin
				predict_pixel_bytes(s_tdata);
			end
			bytes_owed = expected_bytes.size();
		end
	end

endmodule

>>> tb/png_stored_deflate_writer_tb.sv
module png_stored_deflate_writer_tb;
	import psdw_pkg::*;

	localparam int RANDOM_PIXELS = 215;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES = 20;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [31:0]      s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	logic             m_tuser;
	logic             cfg_we = 1'b0;
	logic             cfg_index = REG_WIDTH;
	logic [DIM_W-1:0] cfg_data = '0;

	int mismatch_count;
	int bytes_owed;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	always #4 clk = ~clk;

	png_stored_deflate_writer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	png_stream_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.bytes_owed     (bytes_owed)
	);

	// Idle stretches: mostly short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] random_pixel();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Offers one pixel word, after an optional gap, and returns at the edge that takes it.
	task automatic send_pixel(input logic [31:0] px);
		int gap;
		gap = 0;
		if (!tx_steady && $urandom_range(0, 99) < 30) begin
			gap = idle_len();
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stops offering pixels and waits until every byte due has come out.
	task automatic close_burst();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (bytes_owed != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_reg(input logic idx, input logic [DIM_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: ready with random stalls, except in steady stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (!rx_steady && $urandom_range(0, 99) < 25) begin
				stall_left <= idle_len();
			end
		end
	end

	// Watchdog on cycles in which neither stream moves a word.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int random_sent;
		int w;
		int h;
		int wu;
		int hu;
		int npix;
		int i;
		random_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One pixel at the reset dimensions, then the image is cut short by shrinking to 1 x 1.
		send_pixel(32'h0000_0000);
		close_burst();
		set_dims('0, '0);
		send_pixel(32'hFFFF_FFFF);
		close_burst();

		// One-pixel image: the second pixel only releases the trailer.
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		close_burst();

		// Small image with two rows.
		set_dims(DIM_W'(3), DIM_W'(2));
		send_pixel(32'hFF00_FF00);
		send_pixel(32'h00FF_00FF);
		send_pixel(32'h8080_8080);
		send_pixel(32'h7F7F_7F7F);
		send_pixel(32'hA5A5_5A5A);
		send_pixel(32'h1234_5678);
		close_burst();

		// Oversized width, ended by narrowing the row while the image is open.
		set_dims(DIM_W'(8191), DIM_W'(1));
		send_pixel(random_pixel());
		send_pixel(random_pixel());
		send_pixel(random_pixel());
		close_burst();
		write_reg(REG_WIDTH, DIM_W'(2));
		send_pixel(random_pixel());
		close_burst();

		// Oversized height, ended by lowering it while the image is open.
		set_dims(DIM_W'(1), DIM_W'(4097));
		send_pixel(random_pixel());
		send_pixel(random_pixel());
		close_burst();
		write_reg(REG_HEIGHT, DIM_W'(1));
		send_pixel(random_pixel());
		close_burst();

		// Random small images, now and then cut short.
		while (random_sent < RANDOM_PIXELS) begin
			w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
			wu = (w == 0) ? 1 : w;
			hu = (h == 0) ? 1 : h;
			set_dims(DIM_W'(w), DIM_W'(h));
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			npix = $urandom_range(1, 3) * wu * hu;
			if (wu * hu == 1) begin
				npix = npix * 2;
			end
			if ($urandom_range(0, 7) == 0) begin
				npix = $urandom_range(1, npix);
			end
			// The last image stops at the pixel budget.
			if (npix > RANDOM_PIXELS - random_sent) begin
				npix = RANDOM_PIXELS - random_sent;
			end
			for (i = 0; i < npix; i++) begin
				send_pixel(random_pixel());
			end
			random_sent += npix;
			close_burst();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0 && bytes_owed == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/psdw_pkg.sv
hw/rtl/psdw_front.sv
hw/rtl/psdw_fifo.sv
hw/rtl/psdw_back.sv
hw/rtl/png_stored_deflate_writer.sv
tb/png_stream_checker.sv
tb/png_stored_deflate_writer_tb.sv
